### hw/rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared widths, register indexes, status codes and bundle types.
// ----------------------------------------------------------------------------
package uer_pkg;

  // Saturation width of the microsecond counter and of the distance count.
  localparam int US_BITS   = 24;
  localparam int CM_BITS   = 16;
  localparam int TPU_BITS  = 10;
  localparam int TRIG_BITS = 8;
  localparam int MPC_BITS  = 8;
  localparam int OFS_BITS  = 8;
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_IDX_BITS  = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TICKS_PER_US = 3'd0,
    REG_TRIGGER_US   = 3'd1,
    REG_TIMEOUT_US   = 3'd2,
    REG_US_PER_CM    = 3'd3,
    REG_OFFSET_CM    = 3'd4
  } reg_idx_t;

  // Measurement status codes.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_RISE_TMO  = 2'd1,
    STAT_FALL_TMO  = 2'd2
  } status_t;

  localparam logic [TPU_BITS-1:0]  TPU_RST     = TPU_BITS'(50);
  localparam logic [TRIG_BITS-1:0] TRIG_RST    = TRIG_BITS'(10);
  localparam logic [US_BITS-1:0]   TIMEOUT_RST = US_BITS'(1000000);
  localparam logic [MPC_BITS-1:0]  MPC_RST     = MPC_BITS'(58);
  localparam logic [OFS_BITS-1:0]  OFS_RST     = OFS_BITS'(8);

  typedef struct packed {
    logic [TPU_BITS-1:0]  ticks_per_us;
    logic [TRIG_BITS-1:0] trigger_us;
    logic [US_BITS-1:0]   timeout_us;
    logic [MPC_BITS-1:0]  us_per_cm;
    logic [OFS_BITS-1:0]  offset_cm;
  } cfg_t;

  typedef struct packed {
    logic                trigger;
    logic                busy;
    logic                done;
    status_t             status;
    logic [CM_BITS-1:0]  distance;
  } res_t;

endpackage

### hw/rtl/uer_engine.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger measurement engine
// Phase sequencer with microsecond and centimeter prescalers, one tick per beat.
// ----------------------------------------------------------------------------
module uer_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic          start_req,
  input  logic          echo_level,
  input  uer_pkg::cfg_t cfg,
  output uer_pkg::res_t res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_RISE = 2'd2,
    PH_FALL = 2'd3
  } phase_t;

  localparam logic [uer_pkg::US_BITS-1:0] US_MAX = '1;
  localparam logic [uer_pkg::CM_BITS-1:0] CM_MAX = '1;

  phase_t                          phase_r, phase_nxt, eph;
  logic [uer_pkg::TPU_BITS-1:0]    tick_pre_r, tick_pre_nxt, tp_base;
  logic [uer_pkg::US_BITS-1:0]     us_cnt_r, us_cnt_nxt, us_base, us_inc;
  logic [uer_pkg::MPC_BITS-1:0]    cm_pre_r, cm_pre_nxt, cp_base;
  logic [uer_pkg::CM_BITS-1:0]     cm_cnt_r, cm_cnt_nxt, cm_base;
  logic                            clear, us_done, trig_end, tmo;
  logic [uer_pkg::TPU_BITS:0]      tp_p1;
  logic [uer_pkg::MPC_BITS:0]      cp_p1;
  logic [uer_pkg::CM_BITS-1:0]     ofs_ext;

  always_comb begin
    // A start from idle, or the echo rise, restarts all counters this tick.
    clear = 1'b0;
    eph   = phase_r;
    if (phase_r == PH_IDLE && start_req) begin
      eph   = PH_TRIG;
      clear = 1'b1;
    end else if (phase_r == PH_RISE && echo_level) begin
      eph   = PH_FALL;
      clear = 1'b1;
    end
    tp_base = clear ? '0 : tick_pre_r;
    us_base = clear ? '0 : us_cnt_r;
    cp_base = clear ? '0 : cm_pre_r;
    cm_base = clear ? '0 : cm_cnt_r;

    tp_p1    = {1'b0, tp_base} + 1'b1;
    us_done  = tp_p1 >= {1'b0, cfg.ticks_per_us};
    us_inc   = (us_base == US_MAX) ? us_base : us_base + 1'b1;
    trig_end = us_inc >= {{(uer_pkg::US_BITS-uer_pkg::TRIG_BITS){1'b0}}, cfg.trigger_us};
    tmo      = us_inc >= cfg.timeout_us;
    cp_p1    = {1'b0, cp_base} + 1'b1;
    ofs_ext  = {{(uer_pkg::CM_BITS-uer_pkg::OFS_BITS){1'b0}}, cfg.offset_cm};

    // Default: timebase advances by one tick.
    phase_nxt    = eph;
    tick_pre_nxt = us_done ? '0 : tp_p1[uer_pkg::TPU_BITS-1:0];
    us_cnt_nxt   = us_done ? us_inc : us_base;
    cm_pre_nxt   = cp_base;
    cm_cnt_nxt   = cm_base;
    res          = '0;

    case (eph)
      PH_TRIG: begin
        res.trigger = 1'b1;
        if (us_done && trig_end) begin
          phase_nxt    = PH_RISE;
          tick_pre_nxt = '0;
          us_cnt_nxt   = '0;
          cm_pre_nxt   = '0;
          cm_cnt_nxt   = '0;
        end
      end
      PH_RISE: begin
        if (us_done && tmo) begin
          phase_nxt  = PH_IDLE;
          res.done   = 1'b1;
          res.status = uer_pkg::STAT_RISE_TMO;
        end
      end
      PH_FALL: begin
        if (!echo_level) begin
          phase_nxt    = PH_IDLE;
          tick_pre_nxt = tp_base;
          us_cnt_nxt   = us_base;
          res.done     = 1'b1;
          res.distance = (cm_base > ofs_ext) ? cm_base - ofs_ext : '0;
        end else if (us_done) begin
          if (cp_p1 >= {1'b0, cfg.us_per_cm}) begin
            cm_pre_nxt = '0;
            cm_cnt_nxt = (cm_base == CM_MAX) ? cm_base : cm_base + 1'b1;
          end else begin
            cm_pre_nxt = cp_p1[uer_pkg::MPC_BITS-1:0];
          end
          if (tmo) begin
            phase_nxt  = PH_IDLE;
            res.done   = 1'b1;
            res.status = uer_pkg::STAT_FALL_TMO;
          end
        end
      end
      default: begin
        // Idle without a start leaves every counter where it was.
        tick_pre_nxt = tick_pre_r;
        us_cnt_nxt   = us_cnt_r;
      end
    endcase
    res.busy = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tick_pre_r <= '0;
      us_cnt_r   <= '0;
      cm_pre_r   <= '0;
      cm_cnt_r   <= '0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      tick_pre_r <= tick_pre_nxt;
      us_cnt_r   <= us_cnt_nxt;
      cm_pre_r   <= cm_pre_nxt;
      cm_cnt_r   <= cm_cnt_nxt;
    end
  end

endmodule

### hw/rtl/ultrasonic_echo_ranger_unit.sv
// The result of an accepted input beat is registered and appears in the cycle after it.
// Throughput: one beat per cycle; the input is ready whenever the result
// register is empty or is being taken in the same cycle.
// Reset (rst_n low at a clock edge, synchronous) returns the sequencer to
// idle, clears all counters, empties the result register, and loads the
// configuration registers with their default values.
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger top level
// Trigger / echo timing for a pulse-echo range sensor, one sampled tick per
// input beat, with a register port for timing and scaling settings.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel: one beat per sampled clock tick of the sensor pins.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_start_req,
  input  logic        in_echo_level,
  // Result channel: one beat for every input beat.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_trigger_level,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [1:0]  out_status,
  output logic [uer_pkg::CM_BITS-1:0]        out_range_cm,
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [uer_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [uer_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  uer_pkg::cfg_t cfg_r;
  uer_pkg::res_t res;
  uer_pkg::res_t res_r;
  logic          out_valid_r;
  logic          accept;

  // The result register parts the two channels. A new beat is taken when
  // the register is empty or its current beat leaves in this same cycle,
  // so the engine advances exactly once per accepted beat.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Configuration registers. Writes outside the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_us <= uer_pkg::TPU_RST;
      cfg_r.trigger_us   <= uer_pkg::TRIG_RST;
      cfg_r.timeout_us   <= uer_pkg::TIMEOUT_RST;
      cfg_r.us_per_cm    <= uer_pkg::MPC_RST;
      cfg_r.offset_cm    <= uer_pkg::OFS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        uer_pkg::REG_TICKS_PER_US: cfg_r.ticks_per_us <= cfg_wdata[uer_pkg::TPU_BITS-1:0];
        uer_pkg::REG_TRIGGER_US:   cfg_r.trigger_us   <= cfg_wdata[uer_pkg::TRIG_BITS-1:0];
        uer_pkg::REG_TIMEOUT_US:   cfg_r.timeout_us   <= cfg_wdata[uer_pkg::US_BITS-1:0];
        uer_pkg::REG_US_PER_CM:    cfg_r.us_per_cm    <= cfg_wdata[uer_pkg::MPC_BITS-1:0];
        uer_pkg::REG_OFFSET_CM:    cfg_r.offset_cm    <= cfg_wdata[uer_pkg::OFS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // The engine works out the next phase, the counters and the result from
  // the beat on the ports and commits its state on the accepting edge.
  uer_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (accept),
    .start_req  (in_start_req),
    .echo_level (in_echo_level),
    .cfg        (cfg_r),
    .res        (res)
  );

  // Result register. Valid is control state; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trigger_level = res_r.trigger;
  assign out_busy_res      = res_r.busy;
  assign out_done_res      = res_r.done;
  assign out_status        = res_r.status;
  assign out_range_cm      = res_r.distance;

endmodule

### hw/rtl/uer_checker.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger port checker
// Assertions on the result channel of the top level, bound to it below.
// ----------------------------------------------------------------------------
module uer_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_trigger_level,
  input logic        out_busy_res,
  input logic        out_done_res,
  input logic [1:0]  out_status,
  input logic [uer_pkg::CM_BITS-1:0] out_range_cm
);

  // A beat that ends no measurement carries no status and no distance.
  a_quiet_when_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_status == uer_pkg::STAT_OK && out_range_cm == '0)
    else $error("status or distance set without done");

  // A timeout reports zero distance.
  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != uer_pkg::STAT_OK |-> out_range_cm == '0)
    else $error("nonzero distance on a timeout");

  // The end of a measurement leaves the unit idle, and the trigger only
  // drives while a measurement is under way.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_done_res || out_trigger_level) |-> out_busy_res != out_done_res)
    else $error("busy flag inconsistent with done or trigger");

  // A stalled result beat holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_range_cm) && $stable(out_status))
    else $error("result beat changed while stalled");

endmodule

bind ultrasonic_echo_ranger_unit uer_port_checker u_uer_port_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_trigger_level (out_trigger_level),
  .out_busy_res      (out_busy_res),
  .out_done_res      (out_done_res),
  .out_status        (out_status),
  .out_range_cm      (out_range_cm)
);
